### design/mexp_pkg.sv
// shared types for the modular exponentiation core
package mexp_pkg;

  typedef enum logic [1:0] {
    MUL_REDUCE,
    MUL_ACC,
    MUL_SQUARE
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     start_mul;
    mul_sel_t mul_sel;
    logic     shift_e;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic e_zero;
    logic e_lsb;
    logic e_rest_zero;
    logic out_valid;
  } dp_stat_t;

  localparam int FIELD_W = 32;
  localparam int ADDR_W  = 3;
  localparam logic [ADDR_W-3:0] REG_MODULUS = '0;

endpackage

### design/modular_exponentiation_core.sv
// top level: modular exponentiation with apb modulus register
// each item runs one reduce, one multiply per set exponent bit and one square per
//   further bit up to the top set one; run time is set by the serial multiplier
// one item at a time, but the next transfer is taken while a result waits;
//   a zero exponent skips the multiplier
module modular_exponentiation_core import mexp_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [2*FIELD_W-1:0] s_tdata,   // base, exponent
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [FIELD_W-1:0]   m_tdata    // power
);

  logic [FIELD_W-1:0] modulus;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  assign pready = 1'b1;

  // synchronous reset, modulus resets to 1
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= FIELD_W'(1);
    end else if (psel && penable && pwrite &&
                 paddr[ADDR_W-1:2] == REG_MODULUS) begin
      modulus <= pwdata;
    end
  end

  assign prdata = (paddr[ADDR_W-1:2] == REG_MODULUS) ? modulus : '0;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mexp_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .base      (s_tdata[FIELD_W-1:0]),
    .exponent  (s_tdata[2*FIELD_W-1:FIELD_W]),
    .modulus   (modulus),
    .out_ready (m_tready),
    .power     (m_tdata)
  );

  assign m_tvalid = stat.out_valid;

endmodule

### design/mexp_mulser.sv
// bit-serial modular multiplier, one double or add step per cycle
module mexp_mulser import mexp_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WIDTH - 1);

  logic             busy;
  logic             phase;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] a_r;
  logic [WIDTH-1:0] b_r;

  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   diff;
  logic [WIDTH-1:0] sum_red;

  // one adder serves both the doubling and the add step
  always_comb begin
    sum  = {1'b0, acc} + {1'b0, (phase ? a_r : acc)};
    diff = sum - {1'b0, m};
    if (m != '0 && sum >= {1'b0, m}) begin
      sum_red = diff[WIDTH-1:0];
    end else begin
      sum_red = sum[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= LAST_BIT;
        acc   <= '0;
        a_r   <= a;
        b_r   <= b;
      end else if (busy) begin
        acc <= sum_red;
        if (!phase && b_r[WIDTH-1]) begin
          phase <= 1'b1;
        end else begin
          phase <= 1'b0;
          b_r   <= {b_r[WIDTH-2:0], 1'b0};
          if (cnt == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
      end
    end
  end

  assign result = acc;

endmodule

### design/mexp_datapath.sv
// operand registers, exponent shifter and output register
module mexp_datapath import mexp_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [FIELD_W-1:0] base,
  input  logic [FIELD_W-1:0] exponent,
  input  logic [FIELD_W-1:0] modulus,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] power
);

  logic [WIDTH-1:0] sq;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] e;
  mul_sel_t         dest_sel;
  logic             out_valid;
  logic [FIELD_W-1:0] out_data;

  logic [WIDTH+FIELD_W-1:0] base_ext;
  logic [WIDTH+FIELD_W-1:0] exp_ext;
  logic [WIDTH+FIELD_W-1:0] mod_ext;
  logic [WIDTH+FIELD_W-1:0] acc_ext;
  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] one_mod;
  logic [WIDTH-1:0] mul_a;
  logic [WIDTH-1:0] mul_b;
  logic             mul_done;
  logic [WIDTH-1:0] mul_result;

  always_comb begin
    base_ext = {{WIDTH{1'b0}}, base};
    exp_ext  = {{WIDTH{1'b0}}, exponent};
    mod_ext  = {{WIDTH{1'b0}}, modulus};
    acc_ext  = {{FIELD_W{1'b0}}, acc};
    m        = mod_ext[WIDTH-1:0];
    one_mod  = (m == WIDTH'(1)) ? '0 : WIDTH'(1);
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_REDUCE: begin
        mul_a = one_mod;
        mul_b = sq;
      end
      MUL_ACC: begin
        mul_a = sq;
        mul_b = acc;
      end
      default: begin
        mul_a = sq;
        mul_b = sq;
      end
    endcase
  end

  mexp_mulser #(.WIDTH(WIDTH)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.start_mul),
    .a      (mul_a),
    .b      (mul_b),
    .m      (m),
    .done   (mul_done),
    .result (mul_result)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq  <= base_ext[WIDTH-1:0];
      e   <= exp_ext[WIDTH-1:0];
      acc <= WIDTH'(1);
    end else begin
      if (cmd.shift_e) begin
        e <= e >> 1;
      end
      if (mul_done) begin
        if (dest_sel == MUL_ACC) begin
          acc <= mul_result;
        end else begin
          sq <= mul_result;
        end
      end
    end
    if (cmd.start_mul) begin
      dest_sel <= cmd.mul_sel;
    end
    if (cmd.out_load) begin
      out_data <= acc_ext[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.mul_done    = mul_done;
    stat.e_zero      = (e == '0);
    stat.e_lsb       = e[0];
    stat.e_rest_zero = ((e >> 1) == '0);
    stat.out_valid   = out_valid;
  end

  assign power = out_data;

endmodule

### design/mexp_ctrl.sv
// sequencer for right-to-left square and multiply
module mexp_ctrl import mexp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    RED_WAIT,
    TEST,
    MUL_WAIT,
    SHIFT,
    SQ_WAIT,
    FINISH
  } state_t;

  state_t state;

  // load stays high for the whole idle state so the operands are taken at the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      cmd      <= '0;
      cmd.load <= 1'b1;
    end else begin
      cmd <= '0;
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= CHECK;
          end else begin
            cmd.load <= 1'b1;
          end
        end
        CHECK: begin
          if (stat.e_zero) begin
            state <= FINISH;
          end else begin
            cmd.start_mul <= 1'b1;
            cmd.mul_sel   <= MUL_REDUCE;
            state         <= RED_WAIT;
          end
        end
        RED_WAIT: begin
          if (stat.mul_done) begin
            state <= TEST;
          end
        end
        TEST: begin
          if (stat.e_lsb) begin
            cmd.start_mul <= 1'b1;
            cmd.mul_sel   <= MUL_ACC;
            state         <= MUL_WAIT;
          end else begin
            state <= SHIFT;
          end
        end
        MUL_WAIT: begin
          if (stat.mul_done) begin
            state <= SHIFT;
          end
        end
        SHIFT: begin
          cmd.shift_e <= 1'b1;
          if (stat.e_rest_zero) begin
            state <= FINISH;
          end else begin
            cmd.start_mul <= 1'b1;
            cmd.mul_sel   <= MUL_SQUARE;
            state         <= SQ_WAIT;
          end
        end
        SQ_WAIT: begin
          if (stat.mul_done) begin
            state <= TEST;
          end
        end
        FINISH: begin
          if (!stat.out_valid || out_ready) begin
            cmd.out_load <= 1'b1;
            cmd.load     <= 1'b1;
            state        <= IDLE;
          end
        end
        default: begin
          cmd.load <= 1'b1;
          state    <= IDLE;
        end
      endcase
    end
  end

  assign in_ready = (state == IDLE);

endmodule
